FILE: design/psets_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psets_pkg
// Shared widths, register indexes and reset values for the per-second
// epoch and transmit-slot timer.
// ----------------------------------------------------------------------------
package psets_pkg;

  // Input field widths
  localparam int unsigned MinutesW = 6;
  localparam int unsigned SecondsW = 6;

  // Configuration register widths
  localparam int unsigned TxSlotW       = 4;
  localparam int unsigned SamplePeriodW = 8;
  localparam int unsigned SessionDelayW = 8;
  localparam int unsigned CalPeriodW    = 10;
  localparam int unsigned CalOnTimeW    = 8;
  localparam int unsigned CfgDataW      = 10;
  localparam int unsigned CfgIndexW     = 3;

  // State widths
  localparam int unsigned SampleCountW = 8;
  localparam int unsigned WindowCountW = 16;
  localparam int unsigned EpochCountW  = 11;

  // Minute arithmetic for the slot bounds (15 * 5 + 4 fits in 7 bits)
  localparam int unsigned MinuteCalcW = 7;
  localparam logic [MinuteCalcW-1:0] SlotMinutes  = 7'd5;
  localparam logic [TxSlotW-1:0]     LastSlot     = 4'd11;
  localparam logic [SecondsW-1:0]    HalfMinute   = 6'd30;

  // Reset values of the configuration registers
  localparam logic [TxSlotW-1:0]       TxSlotReset       = 4'd0;
  localparam logic [SamplePeriodW-1:0] SamplePeriodReset = 8'd200;
  localparam logic [SessionDelayW-1:0] SessionDelayReset = 8'd5;
  localparam logic [CalPeriodW-1:0]    CalPeriodReset    = 10'd54;
  localparam logic [CalOnTimeW-1:0]    CalOnTimeReset    = 8'd3;

  // Configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    REG_TX_SLOT       = 3'd0,
    REG_SAMPLE_PERIOD = 3'd1,
    REG_SESSION_DELAY = 3'd2,
    REG_CAL_PERIOD    = 3'd3,
    REG_CAL_ON_TIME   = 3'd4
  } reg_index_t;

endpackage

FILE: design/psets_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psets_tick_if / psets_result_if
// Valid/ready channels for the one-second tick request and its result.
// ----------------------------------------------------------------------------
interface psets_tick_if;
  import psets_pkg::*;

  logic                valid;
  logic                ready;
  logic [MinutesW-1:0] minutes;
  logic [SecondsW-1:0] seconds;
  logic                modem_idle;

  modport source (output valid, minutes, seconds, modem_idle, input ready);
  modport sink   (input valid, minutes, seconds, modem_idle, output ready);
endinterface

interface psets_result_if;
  logic valid;
  logic ready;
  logic sample_epoch;
  logic modem_power_up;
  logic session_start;
  logic modem_power_down;
  logic cal_start;
  logic cal_end;

  modport source (output valid, sample_epoch, modem_power_up, session_start,
                  modem_power_down, cal_start, cal_end, input ready);
  modport sink   (input valid, sample_epoch, modem_power_up, session_start,
                  modem_power_down, cal_start, cal_end, output ready);
endinterface

FILE: design/per_second_epoch_and_tx_slot_timer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_second_epoch_and_tx_slot_timer_unit
// Once-per-second run-mode timer: sample epochs, modem window control and
// the self-calibration cycle.
// ----------------------------------------------------------------------------
// Usage:
//   tick   : one request per second carrying minutes, seconds and the modem
//            idle flag. Accepted when tick.valid and tick.ready are high.
//   result : one request per tick with six event flags, valid/ready.
//   wr_*   : register writes (index 0 tx_slot, 1 epoch_period,
//            2 session_delay, 3 cal_period, 4 cal_on_time), taken on any
//            edge with wr_en high; write only while the block is idle.
// The state counters and the result register update at the edge that accepts
// a tick, so the flags appear on the next cycle.
// Throughput is one tick per cycle; the single result register is the only
// buffer, and tick.ready follows result.ready combinationally when the
// register is full. When the receiver stalls, the result is held and a new
// tick is taken only in the cycle that the held result leaves.
// Reset clears all counters and state flags, loads the register defaults and
// empties the result register; tick.ready is low during reset.
// ----------------------------------------------------------------------------
module per_second_epoch_and_tx_slot_timer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [psets_pkg::CfgIndexW-1:0] wr_index,
  input  logic [psets_pkg::CfgDataW-1:0]  wr_data,
  psets_tick_if.sink                    tick,
  psets_result_if.source                result
);
  import psets_pkg::*;

  // Configuration registers
  logic [TxSlotW-1:0]       tx_slot;
  logic [SamplePeriodW-1:0] epoch_period;
  logic [SessionDelayW-1:0] session_delay;
  logic [CalPeriodW-1:0]    cal_period;
  logic [CalOnTimeW-1:0]    cal_on_time;

  // Timer state
  logic [SampleCountW-1:0] sample_count, sample_count_next;
  logic [WindowCountW-1:0] window_tick_count, window_tick_count_next;
  logic                    comms_active, comms_active_next;
  logic [EpochCountW-1:0]  epoch_count, epoch_count_next;
  logic                    in_calibration, in_calibration_next;

  // Event flags for the tick being accepted
  logic epoch, pwr_up, sess, pwr_dn, c_start, c_end;

  logic tick_fire;

  // Intermediate values
  logic [SampleCountW-1:0] sample_inc;
  logic [EpochCountW-1:0]  epoch_after;
  logic [WindowCountW-1:0] window_base;
  logic [MinuteCalcW-1:0]  slot_first, slot_last, mins_ext;
  logic                    slot_ok, in_slot, out_slot;
  logic [EpochCountW-1:0]  cal_stop;

  // Handshake: take a tick whenever the result register is free or leaving
  assign tick.ready = !rst && (!result.valid || result.ready);
  assign tick_fire  = tick.valid && tick.ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_slot       <= TxSlotReset;
      epoch_period  <= SamplePeriodReset;
      session_delay <= SessionDelayReset;
      cal_period    <= CalPeriodReset;
      cal_on_time   <= CalOnTimeReset;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_TX_SLOT:       tx_slot       <= wr_data[TxSlotW-1:0];
        REG_SAMPLE_PERIOD: epoch_period  <= wr_data[SamplePeriodW-1:0];
        REG_SESSION_DELAY: session_delay <= wr_data[SessionDelayW-1:0];
        REG_CAL_PERIOD:    cal_period    <= wr_data[CalPeriodW-1:0];
        REG_CAL_ON_TIME:   cal_on_time   <= wr_data[CalOnTimeW-1:0];
        default: ;
      endcase
    end
  end

  // Sample epoch counter
  always_comb begin
    sample_inc = sample_count + 1'b1;
    epoch      = (sample_inc >= epoch_period);
    sample_count_next = epoch ? '0 : sample_inc;
    epoch_after = epoch ? epoch_count + 1'b1 : epoch_count;
  end

  // Slot bounds: minutes 5*tx_slot .. 5*tx_slot+4
  always_comb begin
    slot_ok    = (tx_slot <= LastSlot);
    slot_first = MinuteCalcW'(tx_slot) * SlotMinutes;
    slot_last  = slot_first + (SlotMinutes - 1'b1);
    mins_ext   = MinuteCalcW'(tick.minutes);
    in_slot    = slot_ok && (mins_ext >= slot_first) && (mins_ext <= slot_last);
    out_slot   = slot_ok && ((mins_ext >= slot_last) || (mins_ext < slot_first));
  end

  // Modem window control
  always_comb begin
    comms_active_next      = comms_active;
    window_tick_count_next = window_tick_count;
    window_base            = window_tick_count;
    pwr_up = 1'b0;
    sess   = 1'b0;
    pwr_dn = 1'b0;
    if (tick.seconds <= HalfMinute) begin
      if (in_slot) begin
        if (!comms_active) begin
          comms_active_next = 1'b1;
          if (tick.modem_idle) begin
            pwr_up      = 1'b1;
            window_base = '0;
          end
        end
        sess = (window_base == WindowCountW'(session_delay));
        window_tick_count_next = window_base + 1'b1;
      end
    end else if (out_slot) begin
      pwr_dn            = 1'b1;
      comms_active_next = 1'b0;
    end
  end

  // Self-calibration cycle
  always_comb begin
    cal_stop            = EpochCountW'(cal_period) + EpochCountW'(cal_on_time);
    epoch_count_next    = epoch_after;
    in_calibration_next = in_calibration;
    c_start = 1'b0;
    c_end   = 1'b0;
    if (epoch_after >= EpochCountW'(cal_period)) begin
      if (!in_calibration) begin
        c_start             = 1'b1;
        in_calibration_next = 1'b1;
      end else if (epoch_after >= cal_stop) begin
        c_end               = 1'b1;
        in_calibration_next = 1'b0;
        epoch_count_next    = '0;
      end
    end
  end

  // State registers, updated once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count      <= '0;
      window_tick_count <= '0;
      comms_active      <= 1'b0;
      epoch_count       <= '0;
      in_calibration    <= 1'b0;
    end else if (tick_fire) begin
      sample_count      <= sample_count_next;
      window_tick_count <= window_tick_count_next;
      comms_active      <= comms_active_next;
      epoch_count       <= epoch_count_next;
      in_calibration    <= in_calibration_next;
    end
  end

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (tick_fire) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (tick_fire) begin
      result.sample_epoch     <= epoch;
      result.modem_power_up   <= pwr_up;
      result.session_start    <= sess;
      result.modem_power_down <= pwr_dn;
      result.cal_start        <= c_start;
      result.cal_end          <= c_end;
    end
  end

  // Power-up and power-down come from opposite halves of the minute.
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.modem_power_up && result.modem_power_down))
    else $error("modem power up and down in the same result");

  // Calibration cannot start and end on the same tick.
  assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.cal_start && result.cal_end))
    else $error("calibration start and end in the same result");

  // Entering calibration is always reported by a start flag.
  assert property (@(posedge clk) disable iff (rst)
    $rose(in_calibration) |-> (result.valid && result.cal_start))
    else $error("calibration entered without a start flag");

  // A session start only happens inside an open window.
  assert property (@(posedge clk) disable iff (rst)
    ($past(tick_fire) && result.session_start) |-> comms_active)
    else $error("session start outside the transmit window");

  // An epoch clears the sample counter.
  assert property (@(posedge clk) disable iff (rst)
    ($past(tick_fire) && result.sample_epoch) |-> (sample_count == '0))
    else $error("sample counter not cleared on epoch");

endmodule

FILE: dv/psets_timer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psets_timer_checker
// Watches the tick and result channels and the register write port of the
// per-second timer. It keeps its own copy of the registers and counters,
// predicts the six event flags of every accepted tick, and compares each
// accepted result with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module psets_timer_checker
  import psets_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CfgIndexW-1:0] wr_index,
  input  logic [CfgDataW-1:0]  wr_data,
  psets_tick_if                tick,
  psets_result_if              result,
  output int                   failures,
  output int                   outstanding
);

  typedef struct packed {
    logic sample_epoch;
    logic modem_power_up;
    logic session_start;
    logic modem_power_down;
    logic cal_start;
    logic cal_end;
  } event_flags_t;

  // Field names indexed by bit position of event_flags_t.
  string flag_name [6] = '{"cal_end", "cal_start", "modem_power_down",
                           "session_start", "modem_power_up", "sample_epoch"};

  // Shadow registers.
  logic [TxSlotW-1:0]       slot_cfg;
  logic [SamplePeriodW-1:0] epoch_period_cfg;
  logic [SessionDelayW-1:0] session_delay_cfg;
  logic [CalPeriodW-1:0]    cal_period_cfg;
  logic [CalOnTimeW-1:0]    cal_on_cfg;

  // Shadow timer state.
  logic [SampleCountW-1:0] sample_ctr;
  logic [WindowCountW-1:0] window_ctr;
  logic                    comms_on;
  logic [EpochCountW-1:0]  epoch_ctr;
  logic                    cal_on;

  // Flags still owed by the block, oldest first.
  event_flags_t pending_flags [$];

  initial begin
    failures    = 0;
    outstanding = 0;
  end

  // Advance the shadow state by one tick and return the flags it raises.
  function automatic event_flags_t predict_flags(input logic [MinutesW-1:0] mins,
                                                 input logic [SecondsW-1:0] secs,
                                                 input logic idle);
    event_flags_t flags;
    logic         slot_valid;
    int unsigned  first_min;
    int unsigned  last_min;
    flags      = '0;
    slot_valid = (slot_cfg <= LastSlot);
    first_min  = slot_cfg * SlotMinutes;
    last_min   = first_min + SlotMinutes - 1;

    // Sample epoch: the counter wraps at its width and clears on an epoch.
    sample_ctr = sample_ctr + 1'b1;
    if (sample_ctr >= epoch_period_cfg) begin
      flags.sample_epoch = 1'b1;
      epoch_ctr          = epoch_ctr + 1'b1;
      sample_ctr         = '0;
    end

    // Transmit window in the first half of the minute, shutdown after it.
    if (secs <= HalfMinute) begin
      if (slot_valid && mins >= first_min && mins <= last_min) begin
        if (!comms_on) begin
          comms_on = 1'b1;
          // A busy modem keeps its window count and gets no power-up.
          if (idle) begin
            flags.modem_power_up = 1'b1;
            window_ctr           = '0;
          end
        end
        if (window_ctr == session_delay_cfg) flags.session_start = 1'b1;
        window_ctr = window_ctr + 1'b1;
      end
    end else begin
      if (slot_valid && (mins >= last_min || mins < first_min)) begin
        flags.modem_power_down = 1'b1;
        comms_on               = 1'b0;
      end
    end

    // Self-calibration: start once the period is reached, end after on-time.
    if (epoch_ctr >= cal_period_cfg) begin
      if (!cal_on) begin
        flags.cal_start = 1'b1;
        cal_on          = 1'b1;
      end else if (epoch_ctr >= cal_period_cfg + cal_on_cfg) begin
        flags.cal_end = 1'b1;
        cal_on        = 1'b0;
        epoch_ctr     = '0;
      end
    end
    return flags;
  endfunction

  always @(posedge clk) begin
    event_flags_t want;
    event_flags_t got;
    if (rst) begin
      slot_cfg          = TxSlotReset;
      epoch_period_cfg  = SamplePeriodReset;
      session_delay_cfg = SessionDelayReset;
      cal_period_cfg    = CalPeriodReset;
      cal_on_cfg        = CalOnTimeReset;
      sample_ctr        = '0;
      window_ctr        = '0;
      comms_on          = 1'b0;
      epoch_ctr         = '0;
      cal_on            = 1'b0;
      pending_flags.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_TX_SLOT:       slot_cfg          = wr_data[TxSlotW-1:0];
          REG_SAMPLE_PERIOD: epoch_period_cfg  = wr_data[SamplePeriodW-1:0];
          REG_SESSION_DELAY: session_delay_cfg = wr_data[SessionDelayW-1:0];
          REG_CAL_PERIOD:    cal_period_cfg    = wr_data[CalPeriodW-1:0];
          REG_CAL_ON_TIME:   cal_on_cfg        = wr_data[CalOnTimeW-1:0];
          default: ;
        endcase
      end

      // Retire a result before queuing a new tick, so a result never
      // matches the prediction made at the same edge.
      if (result.valid && result.ready) begin
        got = '{result.sample_epoch, result.modem_power_up, result.session_start,
                result.modem_power_down, result.cal_start, result.cal_end};
        if (pending_flags.size() == 0) begin
          $error("result request with no tick outstanding: flags %b", got);
          failures++;
        end else begin
          want = pending_flags.pop_front();
          for (int b = 0; b < $bits(event_flags_t); b++) begin
            if (got[b] !== want[b]) begin
              $error("%s: expected %0b, got %0b", flag_name[b], want[b], got[b]);
              failures++;
            end
          end
        end
      end

      if (tick.valid && tick.ready)
        pending_flags.push_back(predict_flags(tick.minutes, tick.seconds, tick.modem_idle));
    end
    outstanding = pending_flags.size();
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the per-second timer with a directed set of ticks, then with
// phases of a running clock under a range of register settings, with random
// gaps on both channels and long receiver stalls. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import psets_pkg::*;

  localparam int TotalItems     = 750;
  localparam int SecsPerMinute  = 60;
  localparam int SecsPerHour    = 3600;
  localparam int LongHold       = 60;
  // Cycles with no request moving on either channel before giving up.
  localparam int WatchdogLimit  = 2000;

  logic                 clk;
  logic                 rst;
  logic                 wr_en;
  logic [CfgIndexW-1:0] wr_index;
  logic [CfgDataW-1:0]  wr_data;
  int                   failures;
  int                   outstanding;
  int                   items_sent;
  bit                   tx_quiet;
  int                   stall_cycles;

  psets_tick_if   tick_ch ();
  psets_result_if result_ch ();

  per_second_epoch_and_tx_slot_timer_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .tick     (tick_ch),
    .result   (result_ch)
  );

  psets_timer_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .tick        (tick_ch),
    .result      (result_ch),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Send one tick request after a random gap; returns at the falling edge
  // after it is taken, with valid still high.
  task automatic send_tick(input logic [MinutesW-1:0] mins,
                           input logic [SecondsW-1:0] secs,
                           input logic idle);
    int gap;
    if (items_sent % 40 == 0) tx_quiet = ($urandom_range(0, 2) == 0);
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.minutes    <= mins;
    tick_ch.seconds    <= secs;
    tick_ch.modem_idle <= idle;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(negedge clk);
    wr_en    <= 1'b0;
  endtask

  // Stop offering ticks and wait until every result has come back.
  task automatic wait_for_results();
    tick_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Result receiver with random stalls, plus two long hold-offs that fill
  // the block and push back on the tick channel.
  initial begin : result_drain
    int rx_count;
    int gap;
    bit rx_quiet;
    rx_count        = 0;
    rx_quiet        = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      if (rx_count % 40 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
      if (rx_count == 150 || rx_count == 500) gap = LongHold;
      else gap = rx_quiet ? 0 : $urandom_range(0, 11);
      @(negedge clk);
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      rx_count++;
    end
  end

  // Watchdog on forward progress.
  initial stall_cycles = 0;
  always @(posedge clk) begin
    if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WatchdogLimit) begin
      $display("** per_second_epoch_and_tx_slot_timer_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    int                  slot;
    int                  period;
    int                  delay;
    int                  cal_per;
    int                  cal_len;
    int                  phase_items;
    int                  slot_base;
    int                  clock_sec;
    int                  pick;
    logic [MinutesW-1:0] mins;
    logic [SecondsW-1:0] secs;

    rst                = 1'b1;
    wr_en              = 1'b0;
    wr_index           = REG_TX_SLOT;
    wr_data            = '0;
    tick_ch.valid      = 1'b0;
    tick_ch.minutes    = '0;
    tick_ch.seconds    = '0;
    tick_ch.modem_idle = 1'b0;
    items_sent         = 0;
    tx_quiet           = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed ticks under the reset settings (slot 0, minutes 0..4).
    send_tick(6'd0, 6'd0, 1'b1);   // window opens on an idle modem
    send_tick(6'd0, 6'd1, 1'b0);
    send_tick(6'd0, 6'd2, 1'b1);
    send_tick(6'd0, 6'd3, 1'b0);
    send_tick(6'd0, 6'd4, 1'b1);
    send_tick(6'd0, 6'd5, 1'b1);   // window count reaches the session delay
    send_tick(6'd0, 6'd6, 1'b1);
    send_tick(6'd0, 6'd30, 1'b0);  // last second of the window half
    send_tick(6'd0, 6'd31, 1'b1);  // second half, not the last minute
    send_tick(6'd3, 6'd59, 1'b1);
    send_tick(6'd4, 6'd30, 1'b1);
    send_tick(6'd4, 6'd31, 1'b0);  // shutdown at the slot's last minute
    send_tick(6'd4, 6'd0, 1'b0);   // window reopens while the modem is busy
    send_tick(6'd4, 6'd1, 1'b1);
    send_tick(6'd63, 6'd63, 1'b1); // both fields out of range
    send_tick(6'd59, 6'd0, 1'b1);
    send_tick(6'd5, 6'd31, 1'b1);  // shutdown outside the slot
    send_tick(6'd2, 6'd10, 1'b1);
    send_tick(6'd60, 6'd30, 1'b0);
    send_tick(6'd62, 6'd45, 1'b1);
    send_tick(6'd1, 6'd62, 1'b0);  // seconds out of range inside the slot
    send_tick(6'd42, 6'd21, 1'b1);
    wait_for_results();

    // Phases of a running clock, each under its own register settings.
    for (int phase = 0; phase < 4 || items_sent < TotalItems; phase++) begin
      phase_items = 70;
      case (phase)
        0: begin
          slot = 3; period = 1; delay = 0; cal_per = 1; cal_len = 1;
        end
        1: begin
          slot = 11; period = 255; delay = 255; cal_per = 1023; cal_len = 255;
        end
        2: begin
          // Slot out of range with zero sample, calibration and on-time.
          slot = 15; period = 0; delay = 2; cal_per = 0; cal_len = 0;
        end
        3: begin
          slot = 12; period = 2; delay = 7; cal_per = 2; cal_len = 0;
        end
        default: begin
          slot        = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 15)
                                                    : $urandom_range(0, 11);
          period      = $urandom_range(0, 6);
          delay       = $urandom_range(0, 20);
          cal_per     = $urandom_range(0, 6);
          cal_len     = $urandom_range(0, 4);
          phase_items = $urandom_range(60, 90);
        end
      endcase
      write_reg(REG_TX_SLOT, CfgDataW'(slot));
      write_reg(REG_SAMPLE_PERIOD, CfgDataW'(period));
      write_reg(REG_SESSION_DELAY, CfgDataW'(delay));
      write_reg(REG_CAL_PERIOD, CfgDataW'(cal_per));
      write_reg(REG_CAL_ON_TIME, CfgDataW'(cal_len));

      // Start the clock a little before the slot opens.
      slot_base = ((slot * SlotMinutes) % SecsPerMinute) * SecsPerMinute;
      clock_sec = (slot_base + SecsPerHour - $urandom_range(0, 40)) % SecsPerHour;

      for (int n = 0; n < phase_items; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          // Noise: any field values, the clock does not advance.
          mins = MinutesW'($urandom_range(0, 63));
          secs = SecondsW'($urandom_range(0, 63));
        end else begin
          if (pick < 10)
            // Jump near the shutdown point of the slot's last minute.
            clock_sec = (slot_base + (SlotMinutes - 1) * SecsPerMinute
                         + $urandom_range(20, 40)) % SecsPerHour;
          else if (pick < 13)
            clock_sec = $urandom_range(0, SecsPerHour - 1);
          else if (pick < 16)
            clock_sec = (slot_base + SecsPerHour - $urandom_range(0, 5)) % SecsPerHour;
          else
            clock_sec = (clock_sec + 1) % SecsPerHour;
          mins = MinutesW'(clock_sec / SecsPerMinute);
          secs = SecondsW'(clock_sec % SecsPerMinute);
        end
        send_tick(mins, secs, $urandom_range(0, 9) < 8);
      end
      wait_for_results();
    end

    // Wait for any stray result before giving the verdict.
    repeat (4) @(negedge clk);
    if (failures == 0)
      $display("** per_second_epoch_and_tx_slot_timer_unit: PASSED **");
    else
      $display("** per_second_epoch_and_tx_slot_timer_unit: FAILED **");
    $finish;
  end

endmodule
